// ===== rtl/hbtm_pkg.sv =====
package hbtm_pkg;

  localparam int NODES_DEF   = 16;
  localparam int NODE_W      = 4;
  localparam int TIME_W      = 31;
  localparam int MAX_NODES   = 1 << NODE_W;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(5);

  // register index as decoded from paddr[2]
  localparam logic REG_IDX_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    MODE_HB    = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_SCAN  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic hb_wr;
    logic scan_start;
    logic scan_step;
    logic load_query;
    logic load_scan;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic emit_final;
  } sts_t;

  // signed gap now - past compared against the timeout; never wraps in 32 bits
  function automatic logic gap_exceeds(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] past,
                                       input logic [TIME_W-1:0] limit);
    logic signed [TIME_W:0] gap;
    logic signed [TIME_W:0] lim;
    gap = signed'({1'b0, now}) - signed'({1'b0, past});
    lim = signed'({1'b0, limit});
    return gap > lim;
  endfunction

endpackage

// ===== rtl/hbtm_ram.sv =====
module hbtm_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/hbtm_ctrl.sv =====
module hbtm_ctrl import hbtm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_mode)
            MODE_HB: begin
              cmd.hb_wr = 1'b1;
            end
            MODE_QUERY: begin
              state_nxt = ST_QUERY;
            end
            MODE_SCAN: begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            default: begin
              // unknown mode: drop the word
            end
          endcase
        end
      end
      ST_QUERY: begin
        if (sts.out_free) begin
          cmd.load_query = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_scan = 1'b1;
          if (sts.emit_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hbtm_dp.sv =====
module hbtm_dp import hbtm_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [NODE_W-1:0] in_node,
  input  logic [TIME_W-1:0] in_time_req,
  input  logic [TIME_W-1:0] timeout,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_node_out,
  output logic              out_alive,
  output logic              out_none_dead,
  output logic              out_last
);

  // only the first MAX_NODES indexes are reachable through the node field
  localparam int DEPTH = (NODES < MAX_NODES) ? NODES : MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int KW    = CW + NODE_W;

  logic [NODE_W-1:0] node_r;
  logic [TIME_W-1:0] time_r;
  logic [DEPTH-1:0]  seen_r;
  logic [DEPTH-1:0]  dead_r;
  logic [CW-1:0]     scan_cnt_r;
  logic              chk_vld_r;
  logic [AW-1:0]     chk_idx_r;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_node_r;
  logic              out_alive_r;
  logic              out_none_dead_r;
  logic              out_last_r;

  logic [AW-1:0]     in_idx;
  logic [AW-1:0]     node_idx;
  logic              in_ok;
  logic              node_ok;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_data;
  logic              wr_en;
  logic              exceeds;
  logic [DEPTH-1:0]  dead_rest;
  logic              dead_any;
  logic [AW-1:0]     low_idx;

  assign in_idx   = in_node[AW-1:0];
  assign node_idx = node_r[AW-1:0];
  assign in_ok    = KW'(in_node) < KW'(DEPTH);
  assign node_ok  = KW'(node_r) < KW'(DEPTH);
  assign wr_en    = cmd.hb_wr && in_ok;

  always_comb begin
    if (cmd.accept) begin
      rd_addr = in_idx;
    end else if (cmd.scan_step) begin
      rd_addr = scan_cnt_r[AW-1:0];
    end else begin
      rd_addr = node_idx;
    end
  end

  hbtm_ram #(
    .WIDTH(TIME_W),
    .DEPTH(DEPTH)
  ) u_last_seen (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(in_idx),
    .wr_data(in_time_req),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign exceeds = gap_exceeds(time_r, rd_data, timeout);

  // lowest pending dead node
  always_comb begin
    low_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (dead_r[i]) begin
        low_idx = AW'(i);
      end
    end
  end

  assign dead_rest = dead_r & (dead_r - DEPTH'(1));
  assign dead_any  = |dead_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      node_r <= in_node;
      time_r <= in_time_req;
    end
    chk_idx_r <= scan_cnt_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      dead_r     <= '0;
      scan_cnt_r <= '0;
      chk_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        seen_r[in_idx] <= 1'b1;
      end
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_step) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      chk_vld_r <= cmd.scan_step && (scan_cnt_r < CW'(DEPTH));
      if (cmd.scan_start) begin
        dead_r <= '0;
      end else if (chk_vld_r && seen_r[chk_idx_r] && exceeds) begin
        dead_r[chk_idx_r] <= 1'b1;
      end else if (cmd.load_scan) begin
        dead_r <= dead_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_query || cmd.load_scan) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      out_node_r      <= node_r;
      out_alive_r     <= node_ok && seen_r[node_idx] && !exceeds;
      out_none_dead_r <= 1'b0;
      out_last_r      <= 1'b1;
    end else if (cmd.load_scan) begin
      out_node_r      <= dead_any ? NODE_W'(low_idx) : '0;
      out_alive_r     <= 1'b0;
      out_none_dead_r <= !dead_any;
      out_last_r      <= (dead_rest == '0);
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.scan_end   = (scan_cnt_r == CW'(DEPTH));
  assign sts.emit_final = (dead_rest == '0);

  assign out_valid     = out_valid_r;
  assign out_node_out  = out_node_r;
  assign out_alive     = out_alive_r;
  assign out_none_dead = out_none_dead_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/heartbeat_timeout_monitor_core.sv =====
// Heartbeat timeout monitor: tracks the last heartbeat time of each node.
// Input words (in_valid/in_ready) carry a mode, a node index and a time.
//   heartbeat: stored, no result; the next word is taken at once.
//   query:     one result (out_alive, out_last set) is loaded from the QUERY
//              state once the output is free; input is taken again after that.
//   scan:      walks the last-seen memory one entry a cycle (min(NODES,16)
//              entries, checked from the registered read), then emits each
//              dead node in ascending order, one per cycle while the output is
//              free, the final one with out_last; with no dead node it emits
//              one word with out_none_dead. Input is held off until the final
//              word is loaded.
// Results sit in an output register; a stalled receiver (out_ready low) holds
// the word and the sequence pauses, nothing is lost.
// Query and scan timing follow from the registered read of the last-seen
// memory, which has separate read and write ports.
// Reset (rst_n, synchronous) clears all seen flags, sets the timeout to 5 and
// empties the output. The timeout is written over APB wherever paddr[2] is 0.
module heartbeat_timeout_monitor_core import hbtm_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [NODE_W-1:0] in_node,
  input  logic [TIME_W-1:0] in_time_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_node_out,
  output logic              out_alive,
  output logic              out_none_dead,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic [TIME_W-1:0] timeout_r;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_IDX_TIMEOUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      timeout_r <= pwdata[TIME_W-1:0];
    end
  end

  assign prdata = reg_sel ? DATA_W'(timeout_r) : '0;

  hbtm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_mode (in_mode),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  hbtm_dp #(
    .NODES(NODES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_node      (in_node),
    .in_time_req  (in_time_req),
    .timeout      (timeout_r),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_node_out (out_node_out),
    .out_alive    (out_alive),
    .out_none_dead(out_none_dead),
    .out_last     (out_last)
  );

endmodule

// ===== rtl/hbtm_chk.sv =====
module hbtm_chk import hbtm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_mode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NODE_W-1:0] out_node_out,
  input logic              out_alive,
  input logic              out_none_dead,
  input logic              out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_SCAN) |=> !in_ready)
    else $error("input taken right after a scan was accepted");

  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a scan burst");

  a_none_dead_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_dead |-> out_last && !out_alive && (out_node_out == '0))
    else $error("malformed none-dead word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_out) &&
      $stable(out_alive) && $stable(out_none_dead) && $stable(out_last))
    else $error("stalled output word changed");

endmodule

bind heartbeat_timeout_monitor_core hbtm_chk u_hbtm_chk (.*);
